### rtl/core/frte_pkg.sv
`default_nettype none
package frte_pkg;
  localparam int unsigned ExpBias = 1023;
  localparam int unsigned FracWidth = 52;
  localparam logic [10:0] ExpAllOnes = 11'h7ff;
  localparam logic [62:0] OneBits = 63'h3ff0000000000000;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_ZERO,
    KIND_ONE,
    KIND_ROUND
  } kind_t;

  typedef struct packed {
    logic        sign;
    logic [62:0] mag;
    kind_t       kind;
    logic [62:0] low_mask;
  } dec_t;

  typedef struct packed {
    logic        sign;
    logic [62:0] mag;
    kind_t       kind;
    logic [62:0] whole;
    logic [62:0] unit;
    logic        up;
  } cmp_t;
endpackage
`default_nettype wire

### rtl/core/frte_decode.sv
`default_nettype none
module frte_decode (
  input  wire logic [63:0]  bits,
  output frte_pkg::dec_t    dec
);
  import frte_pkg::*;

  logic [10:0] expo;
  logic [5:0]  drop;
  logic [10:0] ediff;

  assign expo  = bits[62:52];
  assign ediff = expo - 11'(ExpBias);
  assign drop  = 6'(FracWidth) - ediff[5:0];

  always_comb begin
    dec.sign     = bits[63];
    dec.mag      = bits[62:0];
    dec.low_mask = (63'd1 << drop) - 63'd1;
    if (expo == ExpAllOnes || expo >= 11'(ExpBias + FracWidth)) begin
      dec.kind = KIND_PASS;
    end else if (expo < 11'(ExpBias - 1)) begin
      dec.kind = KIND_ZERO;
    end else if (expo == 11'(ExpBias - 1)) begin
      dec.kind = (bits[51:0] == 52'd0) ? KIND_ZERO : KIND_ONE;
    end else begin
      dec.kind = KIND_ROUND;
    end
  end
endmodule
`default_nettype wire

### rtl/core/frte_compare.sv
`default_nettype none
module frte_compare (
  input  wire frte_pkg::dec_t dec,
  output frte_pkg::cmp_t      cmp
);
  import frte_pkg::*;

  logic [62:0] unit;
  logic [62:0] half;
  logic [62:0] rest;
  logic [62:0] whole;

  assign unit  = dec.low_mask + 63'd1;
  assign half  = unit >> 1;
  assign rest  = dec.mag & dec.low_mask;
  assign whole = dec.mag & ~dec.low_mask;

  always_comb begin
    cmp.sign  = dec.sign;
    cmp.mag   = dec.mag;
    cmp.kind  = dec.kind;
    cmp.whole = whole;
    cmp.unit  = unit;
    cmp.up    = (rest > half) || (rest == half && (whole & unit) != 63'd0);
  end
endmodule
`default_nettype wire

### rtl/core/float_round_to_integer_even_top.sv
`default_nettype none
// Rounds one IEEE-754 binary64 per transaction to the nearest integral value, ties to
// even, keeping the sign (negative zero included); NaN, infinity and integral values
// pass unchanged. Three register stages (decode, compare, add); one transaction per
// cycle sustained while the output takes results. Backpressure stalls the whole
// pipeline; bubbles are squeezed out.
module float_round_to_integer_even_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] operand_bits
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // [63:0] rounded_bits
);
  import frte_pkg::*;

  logic        v1, v2, v3;
  dec_t        dec_c, dec_reg;
  cmp_t        cmp_c, cmp_reg;
  logic [63:0] res_next;
  logic        adv3, adv2, adv1;

  assign adv3 = !v3 || m_axis_tready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign s_axis_tready = adv1;

  frte_decode u_decode (.bits(s_axis_tdata), .dec(dec_c));
  frte_compare u_compare (.dec(dec_reg), .cmp(cmp_c));

  always_comb begin
    case (cmp_reg.kind)
      KIND_PASS:  res_next = {cmp_reg.sign, cmp_reg.mag};
      KIND_ZERO:  res_next = {cmp_reg.sign, 63'd0};
      KIND_ONE:   res_next = {cmp_reg.sign, OneBits};
      KIND_ROUND: res_next = {cmp_reg.sign,
                              cmp_reg.up ? cmp_reg.whole + cmp_reg.unit : cmp_reg.whole};
      default:    res_next = {cmp_reg.sign, cmp_reg.mag};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_axis_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
    if (adv1) dec_reg <= dec_c;
    if (adv2) cmp_reg <= cmp_c;
    if (adv3) m_axis_tdata <= res_next;
  end

  assign m_axis_tvalid = v3;
endmodule
`default_nettype wire

### bench/tb_float_round_to_integer_even_top.sv
module tb_float_round_to_integer_even_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Bias = 1023;
  localparam int unsigned FracW = 52;
  localparam int unsigned CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  logic [63:0] rounded_q[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_off = 1'b0;
  int          errors = 0;
  int          cycles = 0;

  float_round_to_integer_even_top dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] round_half_even(input logic [63:0] x);
    logic [10:0] ex;
    logic [63:0] sgn, mg, unit, lowm, rest, half, whole;
    int unsigned drop;
    ex = x[62:52];
    sgn = {x[63], 63'b0};
    mg = {1'b0, x[62:0]};
    if (ex == 11'h7ff || ex >= Bias + FracW) return x;
    if (ex < Bias - 1) return sgn;
    if (ex == Bias - 1) return (x[51:0] == '0) ? sgn : (sgn | 64'h3ff0000000000000);
    drop = FracW - (ex - Bias);
    unit = 64'd1 << drop;
    lowm = unit - 64'd1;
    rest = mg & lowm;
    half = 64'd1 << (drop - 1);
    whole = mg & ~lowm;
    if (rest > half || (rest == half && (whole & unit) != 64'd0)) whole += unit;
    return sgn | whole;
  endfunction

  function automatic logic [63:0] make_double(input bit s, input int unsigned e,
                                              input logic [51:0] f);
    return {s, e[10:0], f};
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[float_round_to_integer_even_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (rounded_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = rounded_q.pop_front();
        if (want !== m_axis_tdata) begin
          $display("%0t mismatch expected %h actual %h", $time, want, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  task automatic send_operand(input logic [63:0] op);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= op;
    do @(posedge clk); while (!s_axis_tready);
    rounded_q.push_back(round_half_even(op));
  endtask

  task automatic test_special_values();
    for (int s = 0; s < 2; s++) begin
      send_operand(make_double(1'(s), 0, 52'd0));
      send_operand(make_double(1'(s), 0, 52'hfffffffffffff));
      send_operand(make_double(1'(s), 2047, 52'd0));
      send_operand(make_double(1'(s), 2047, 52'h8000000000001));
      send_operand(make_double(1'(s), 1022, 52'd0));
      send_operand(make_double(1'(s), 1022, 52'd1));
      send_operand(make_double(1'(s), 1021, 52'hfffffffffffff));
      send_operand(make_double(1'(s), 1023, 52'h8000000000000));
      send_operand(make_double(1'(s), 1024, 52'h4000000000000));
      send_operand(make_double(1'(s), 1074, 52'hfffffffffffff));
      send_operand(make_double(1'(s), 1075, 52'h123456789abcd));
      send_operand(make_double(1'(s), 2046, 52'hfffffffffffff));
    end
  endtask

  task automatic test_random_operands(input int n);
    int unsigned e;
    logic [51:0] f;
    for (int i = 0; i < n; i++) begin
      f = 52'({$urandom, $urandom});
      case ($urandom_range(5))
        0: e = $urandom_range(2047);
        1: e = $urandom_range(1076, 1020);
        default: e = $urandom_range(1075, 1022);
      endcase
      if ($urandom_range(3) == 0) begin
        e = $urandom_range(1074, 1023);
        f = f & ~((52'd1 << (1075 - e)) - 52'd1);
        f[1074 - e] = 1'b1;
        f = f & ~((52'd1 << (1074 - e)) - 52'd1);
      end else if ($urandom_range(7) == 0) begin
        f = 52'hfffffffffffff;
      end
      send_operand(make_double(1'($urandom_range(1)), e, f));
    end
  endtask

  task automatic test_backpressure();
    int held;
    hold_off = 1'b1;
    fork
      begin
        held = 0;
        while (held < 60) begin
          @(posedge clk);
          held++;
        end
        hold_off = 1'b0;
      end
      test_random_operands(20);
    join
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 37;
    recv_idle_pct = 76;
    test_special_values();
    test_random_operands(500);
    send_idle_pct = 76;
    recv_idle_pct = 37;
    test_random_operands(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_operands(560);
    s_axis_tvalid <= 1'b0;
    while (rounded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[float_round_to_integer_even_top] OK");
    end else begin
      $display("[float_round_to_integer_even_top] ERROR");
    end
    $finish;
  end
endmodule
